// ===== sv/psh_pkg.sv =====
// Shared constants, lookup table and queue item type for the polynomial string hash.
package psh_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned HashW = 30;
  localparam int unsigned MagW  = 38;  // |term| * power, |term| <= 224

  localparam longint unsigned HASH_MOD_L  = 64'd1000000009;
  localparam longint unsigned HASH_BASE_L = 64'd31;

  localparam logic [HashW-1:0] HASH_MOD    = 30'd1000000009;
  localparam logic [31:0]      HASH_MOD_X2 = 32'd2000000018;
  // 2^30 mod HASH_MOD, used to fold bits above bit 29 back into range
  localparam logic [HashW-1:0] FOLD_K      = 30'd73741815;
  // 2^64 mod HASH_MOD: a negative 64-bit sum v stands for 2^64 + v
  localparam logic [HashW-1:0] WRAP_REM    =
    30'((64'hFFFF_FFFF_FFFF_FFFF % HASH_MOD_L + 64'd1) % HASH_MOD_L);

  localparam logic signed [ByteW:0] TERM_OFFSET = 9'sd96;

  // Entry i holds floor(31 * (i << 22) / M) * M; index with power[29:22].
  typedef logic [34:0] pow_tab_t [256];

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t        tab;
    longint unsigned lo;
    for (int i = 0; i < 256; i++) begin
      lo     = longint'(i) << 22;
      tab[i] = 35'(((HASH_BASE_L * lo) / HASH_MOD_L) * HASH_MOD_L);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

  // Decoded item handed from the front pipeline to the hash accumulator.
  typedef struct packed {
    logic             is_end;  // zero byte: emit and restart
    logic             neg;     // term below zero
    logic [MagW-1:0]  mag;     // |term| * power, unreduced
    logic [HashW-1:0] addend;  // value to add mod M when no exact subtract applies
  } psh_op_t;

endpackage

// ===== sv/polynomial_string_hash_top.sv =====
// Top level of the polynomial string hash (base 31, modulus 1000000009).
//
// Feed a zero-terminated string one byte per item on text_byte_i; bytes are
// read as signed char, and each nonzero byte adds (byte - 96) * 31^k to the
// running hash, where k counts bytes since the string began. The sum wraps
// like 64-bit two's-complement before it is reduced mod 1000000009, so bytes
// below 0x60 and bytes 0x80..0xFF give the same wrapped results as 64-bit
// software. A zero byte returns one item on digest_o (0 for an empty
// string) and restarts with hash 0 and power 1; nonzero bytes return nothing.
// Throughput is one byte per clock with no gaps between strings while the
// output is taken; a held output can fill the queue and stall the input.
// The two loops that set this are the power update in the front (31 * p
// mod M via a 256-entry quotient table and one correction) and the
// accumulate step in the back (one add or subtract mod M). The term product
// and its reduction run in a five-stage front pipeline. A small queue
// (QUEUE_DEPTH items) sits between front and back, and the output register
// lets the back keep taking bytes while a finished hash waits to be taken.
// There is no clearing pass and no configuration.
module polynomial_string_hash_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  text_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [29:0] digest_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import psh_pkg::*;

  psh_op_t q_in_op;
  psh_op_t q_op;
  logic    q_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;

  // Front: accept, classify, advance the power, reduce |term| * power.
  psh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_byte_i (text_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_o        (q_in_op),
    .op_valid_o  (q_push),
    .q_full_i    (q_full)
  );

  // Decouple: the front never sees the output handshake directly.
  psh_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_op),
    .pop_i   (q_pop)
  );

  // Back: accumulate the hash, emit on end of string.
  psh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .op_i        (q_op),
    .pop_o       (q_pop),
    .digest_o    (digest_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

`ifndef SYNTHESIS
  // Emitted hashes are always fully reduced.
  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digest_o < HASH_MOD))
    else $error("digest_o out of range");

  // An end item leaves the queue only when the output slot can take it.
  a_end_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_op.is_end) |-> (!out_valid_o || out_ready_i))
    else $error("end item popped onto a held output");

  // Never write a full queue.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue overflow");

  // Popping an end item raises the output valid on the next edge.
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_op.is_end) |=> out_valid_o)
    else $error("end item lost");
`endif

endmodule

// ===== sv/psh_front.sv =====
// Front pipeline: accepts bytes, tracks the power, forms and reduces each term.
module psh_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [7:0]               text_byte_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output psh_pkg::psh_op_t         op_o,
  output logic                     op_valid_o,
  input  logic                     q_full_i
);
  import psh_pkg::*;

  // power register and its next value
  logic [HashW-1:0] pow_q, pow_d;
  logic [34:0]      pow_x31;
  logic [34:0]      pow_r0;
  logic [30:0]      pow_r0n;
  logic [HashW-1:0] pow_nxt;

  logic signed [ByteW:0] term;
  logic                  term_neg;
  logic [ByteW-1:0]      term_abs;
  logic                  accept;
  logic                  is_zero;

  logic [4:0] free;

  logic             s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic             s0_end_q, s1_end_q, s2_end_q, s3_end_q, s4_end_q;
  logic             s0_neg_q, s1_neg_q, s2_neg_q, s3_neg_q, s4_neg_q;
  logic [ByteW-1:0] s0_abs_q;
  logic [HashW-1:0] s0_pow_q;
  logic [MagW-1:0]  s1_mag_q, s2_mag_q, s3_mag_q, s4_mag_q;
  logic [34:0]      s2_fold_q;
  logic [31:0]      s3_fold_q;
  logic [HashW-1:0] s4_rem_q;

  logic [MagW-1:0]  s1_mag_d;
  logic [34:0]      s2_fold_d;
  logic [31:0]      s3_fold_d;
  logic [HashW-1:0] s4_rem_d;
  logic [30:0]      wrap_d, wrap_dm;

  // classify the byte and form the signed term
  always_comb begin
    is_zero  = (text_byte_i == '0);
    term     = $signed({text_byte_i[7], text_byte_i}) - TERM_OFFSET;
    term_neg = term[ByteW];
    term_abs = term_neg ? 8'(-term) : term[ByteW-1:0];
  end

  // 31 * p mod M: table gives the quotient within one, then one correction
  always_comb begin
    pow_x31 = {pow_q, 5'b0} - {5'b0, pow_q} - POW_TAB[pow_q[29:22]];
    pow_r0  = pow_x31;
    pow_r0n = pow_r0[30:0];
    pow_nxt = (pow_r0n >= {1'b0, HASH_MOD}) ? 30'(pow_r0n - {1'b0, HASH_MOD})
                                             : pow_r0n[HashW-1:0];
  end

  // a stage takes a new item when empty or when its item moves on
  always_comb begin
    free[4] = !s4_vld_q || !q_full_i;
    free[3] = !s3_vld_q || free[4];
    free[2] = !s2_vld_q || free[3];
    free[1] = !s1_vld_q || free[2];
    free[0] = !s0_vld_q || free[1];
  end

  assign in_ready_o = free[0];
  assign accept     = in_valid_i && free[0];

  always_comb begin
    pow_d = pow_q;
    if (accept) begin
      pow_d = is_zero ? 30'd1 : pow_nxt;
    end
  end

  // datapath of the stages
  always_comb begin
    s1_mag_d  = 38'(s0_abs_q) * 38'(s0_pow_q);
    s2_fold_d = 35'(s1_mag_q[37:30]) * 35'(FOLD_K) + 35'(s1_mag_q[29:0]);
    s3_fold_d = 32'(s2_fold_q[34:30]) * 32'(FOLD_K) + 32'(s2_fold_q[29:0]);
    if (s3_fold_q >= HASH_MOD_X2) begin
      s4_rem_d = 30'(s3_fold_q - HASH_MOD_X2);
    end else if (s3_fold_q >= {2'b0, HASH_MOD}) begin
      s4_rem_d = 30'(s3_fold_q - {2'b0, HASH_MOD});
    end else begin
      s4_rem_d = s3_fold_q[HashW-1:0];
    end
  end

  // (2^64 - r) mod M for negative terms
  always_comb begin
    wrap_d  = {1'b0, WRAP_REM} - {1'b0, s4_rem_q};
    wrap_dm = {1'b0, WRAP_REM} + {1'b0, HASH_MOD} - {1'b0, s4_rem_q};
  end

  always_comb begin
    op_o.is_end = s4_end_q;
    op_o.neg    = s4_neg_q;
    op_o.mag    = s4_mag_q;
    op_o.addend = !s4_neg_q ? s4_rem_q
                : (wrap_d[30] ? wrap_dm[HashW-1:0] : wrap_d[HashW-1:0]);
  end

  assign op_valid_o = s4_vld_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_q    <= 30'd1;
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      pow_q <= pow_d;
      if (free[0]) s0_vld_q <= in_valid_i;
      if (free[1]) s1_vld_q <= s0_vld_q;
      if (free[2]) s2_vld_q <= s1_vld_q;
      if (free[3]) s3_vld_q <= s2_vld_q;
      if (free[4]) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      s0_end_q <= is_zero;
      s0_neg_q <= term_neg;
      s0_abs_q <= term_abs;
      s0_pow_q <= pow_q;
    end
    if (free[1]) begin
      s1_end_q <= s0_end_q;
      s1_neg_q <= s0_neg_q;
      s1_mag_q <= s1_mag_d;
    end
    if (free[2]) begin
      s2_end_q  <= s1_end_q;
      s2_neg_q  <= s1_neg_q;
      s2_mag_q  <= s1_mag_q;
      s2_fold_q <= s2_fold_d;
    end
    if (free[3]) begin
      s3_end_q  <= s2_end_q;
      s3_neg_q  <= s2_neg_q;
      s3_mag_q  <= s2_mag_q;
      s3_fold_q <= s3_fold_d;
    end
    if (free[4]) begin
      s4_end_q <= s3_end_q;
      s4_neg_q <= s3_neg_q;
      s4_mag_q <= s3_mag_q;
      s4_rem_q <= s4_rem_d;
    end
  end

endmodule

// ===== sv/psh_queue.sv =====
// Small FIFO of decoded items between the front pipeline and the accumulator.
module psh_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  psh_pkg::psh_op_t data_i,
  output logic             full_o,
  output logic             valid_o,
  output psh_pkg::psh_op_t data_o,
  input  logic             pop_i
);
  import psh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  psh_op_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/psh_back.sv =====
// Hash accumulator and output register.
module psh_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  psh_pkg::psh_op_t op_i,
  output logic             pop_o,
  output logic [29:0]      digest_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);
  import psh_pkg::*;

  logic [HashW-1:0] hash_q, hash_d;
  logic             out_vld_q, out_vld_d;
  logic [HashW-1:0] out_hash_q;
  logic             sub_ok;
  logic [HashW-1:0] sub_val;
  logic [HashW:0]   sum;
  logic [HashW-1:0] sum_red;

  // end items need a free output slot; other items never wait
  assign pop_o = q_valid_i && (!op_i.is_end || !out_vld_q || out_ready_i);

  always_comb begin
    // exact subtract when the 64-bit sum stays non-negative
    sub_ok  = op_i.neg && (op_i.mag[MagW-1:HashW] == '0) && (op_i.mag[HashW-1:0] <= hash_q);
    sub_val = hash_q - op_i.mag[HashW-1:0];
    sum     = {1'b0, hash_q} + {1'b0, op_i.addend};
    sum_red = (sum >= {1'b0, HASH_MOD}) ? 30'(sum - {1'b0, HASH_MOD}) : sum[HashW-1:0];
  end

  always_comb begin
    hash_d    = hash_q;
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (pop_o) begin
      if (op_i.is_end) begin
        hash_d    = '0;
        out_vld_d = 1'b1;
      end else begin
        hash_d = sub_ok ? sub_val : sum_red;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      hash_q    <= hash_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.is_end) begin
      out_hash_q <= hash_q;
    end
  end

  assign digest_o    = out_hash_q;
  assign out_valid_o = out_vld_q;

endmodule
